FILE: hw/rtl/i2ceb_pkg.sv
`default_nettype none

package i2ceb_pkg;

    // Command codes carried in the op field of a request.
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_CUR_READ  = 2'd2,
        OP_RAND_READ = 2'd3
    } op_t;

    // Outcome codes reported on the status field.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NACK_WADDR  = 3'd1,
        ST_NACK_MADDR  = 3'd2,
        ST_NACK_DATA   = 3'd3,
        ST_NACK_RADDR  = 3'd4
    } status_t;

    // Configuration register indexes.
    localparam logic CFG_DEV_ADDR   = 1'b0;
    localparam logic CFG_WAIT_TICKS = 1'b1;

    localparam logic [6:0]  DEV_ADDR_RST   = 7'd80;
    localparam logic [15:0] WAIT_TICKS_RST = 16'd1000;

    // Bus sequencer phases, one-hot.
    typedef enum logic [20:0] {
        PH_IDLE    = 21'h000001,
        PH_STA_A   = 21'h000002,
        PH_STA_B   = 21'h000004,
        PH_TX_PREP = 21'h000008,
        PH_TX_SET  = 21'h000010,
        PH_TX_HI   = 21'h000020,
        PH_TX_LO   = 21'h000040,
        PH_ACK_L1  = 21'h000080,
        PH_ACK_HI  = 21'h000100,
        PH_ACK_L2  = 21'h000200,
        PH_RX_PREP = 21'h000400,
        PH_RX_HI   = 21'h000800,
        PH_RX_LO   = 21'h001000,
        PH_NA_A    = 21'h002000,
        PH_NA_B    = 21'h004000,
        PH_NA_C    = 21'h008000,
        PH_NA_D    = 21'h010000,
        PH_STO_A   = 21'h020000,
        PH_STO_B   = 21'h040000,
        PH_STO_C   = 21'h080000,
        PH_WAIT    = 21'h100000
    } phase_t;

    // One result per tick.
    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] status;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_eeprom_byte_master_top.sv
`default_nettype none
// Channel   Direction  Payload
// s_        in         one bus tick request: op, mem_addr, write_data, sda_in
// m_        out        one result per tick: bus levels, busy, done, status, read_data
// cfg_      in         register write: index 0 device address, index 1 write wait ticks
//
// The bus sequencer computes each request's tick in a single pass
// from its state registers and the request, and the result lands in the output register.
// A new request is accepted every cycle while the output register is empty or being
// drained, so the throughput is one tick per clock.
// A stall on m_tready holds the result and back-pressures s_tready in the same cycle.
// Reset (aresetn low, synchronous) returns the bus to idle and the registers to defaults.

module i2c_eeprom_byte_master_top
    import i2ceb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // op[1:0], mem_addr[9:2], write_data[17:10],
                                        // sda_in[18], zero pad[23:19]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // scl_level[0], sda_level[1], sda_drive[2],
                                        // busy_res[3], done_res[4], status[7:5],
                                        // read_data[15:8]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [6:0]  dev_addr_reg;
    logic [15:0] wait_ticks_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        step_en;
    res_t        res;

    // The output register frees up in the cycle its result is taken.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step_en   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg   <= DEV_ADDR_RST;
            wait_ticks_reg <= WAIT_TICKS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_DEV_ADDR) begin
                dev_addr_reg <= cfg_data[6:0];
            end else begin
                wait_ticks_reg <= cfg_data;
            end
        end
    end

    i2ceb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .op         (s_tdata[1:0]),
        .mem_addr   (s_tdata[9:2]),
        .write_data (s_tdata[17:10]),
        .sda_in     (s_tdata[18]),
        .dev_addr   (dev_addr_reg),
        .wait_ticks (wait_ticks_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_tdata_reg <= {res.read_data, res.status, res.done_res, res.busy_res,
                            res.sda_drive, res.sda_level, res.scl_level};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/i2ceb_core.sv
`default_nettype none

module i2ceb_core
    import i2ceb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  mem_addr,
    input  wire logic [7:0]  write_data,
    input  wire logic        sda_in,
    input  wire logic [6:0]  dev_addr,
    input  wire logic [15:0] wait_ticks,
    output res_t             res
);

    phase_t      phase_reg,    phase_next;
    logic [3:0]  bit_cnt_reg,  bit_cnt_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [1:0]  lop_reg,      lop_next;
    logic [7:0]  laddr_reg,    laddr_next;
    logic [7:0]  ldata_reg,    ldata_next;
    logic [15:0] wait_cnt_reg, wait_cnt_next;
    logic [2:0]  status_reg,   status_next;
    logic [7:0]  rx_byte_reg,  rx_byte_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic        nack_reg,     nack_next;
    logic        last_sda_reg, last_sda_next;

    logic        scl, lvl, drv, busy, done;
    logic [3:0]  bit_cnt_inc;
    phase_t      ph;

    // Byte to transmit for the given transaction and byte position.
    function automatic logic [7:0] pick_byte(input logic [1:0] lop, input logic [1:0] idx,
                                             input logic [7:0] addr, input logic [7:0] data,
                                             input logic [6:0] dev);
        logic [7:0] wr;
        logic [7:0] rd;
        wr = {dev, 1'b0};
        rd = {dev, 1'b1};
        if (lop == OP_WRITE) begin
            pick_byte = (idx == 2'd0) ? wr : ((idx == 2'd1) ? addr : data);
        end else if (lop == OP_CUR_READ) begin
            pick_byte = rd;
        end else begin
            pick_byte = (idx == 2'd0) ? wr : ((idx == 2'd1) ? addr : rd);
        end
    endfunction

    function automatic logic [2:0] fail_code(input logic [1:0] lop, input logic [1:0] idx);
        if (lop == OP_CUR_READ) begin
            fail_code = ST_NACK_RADDR;
        end else if (idx == 2'd0) begin
            fail_code = ST_NACK_WADDR;
        end else if (idx == 2'd1) begin
            fail_code = ST_NACK_MADDR;
        end else begin
            fail_code = (lop == OP_WRITE) ? ST_NACK_DATA : ST_NACK_RADDR;
        end
    endfunction

    assign bit_cnt_inc = bit_cnt_reg + 4'd1;

    always_comb begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        lop_next      = lop_reg;
        laddr_next    = laddr_reg;
        ldata_next    = ldata_reg;
        wait_cnt_next = wait_cnt_reg;
        status_next   = status_reg;
        rx_byte_next  = rx_byte_reg;
        byte_idx_next = byte_idx_reg;
        nack_next     = nack_reg;
        scl  = 1'b1;
        lvl  = 1'b1;
        drv  = 1'b1;
        busy = 1'b1;
        done = 1'b0;
        ph   = phase_reg;

        // A command taken while idle starts its first tick right away.
        if (phase_reg == PH_IDLE && op != OP_TICK) begin
            lop_next      = op;
            laddr_next    = mem_addr;
            ldata_next    = write_data;
            byte_idx_next = 2'd0;
            ph            = PH_STA_A;
        end

        unique case (ph)
            PH_IDLE: begin
                busy = 1'b0;
            end
            PH_STA_A: begin
                phase_next = PH_STA_B;
            end
            PH_STA_B: begin
                lvl        = 1'b0;
                shift_next = pick_byte(lop_reg, byte_idx_reg, laddr_reg, ldata_reg, dev_addr);
                phase_next = PH_TX_PREP;
            end
            PH_TX_PREP: begin
                scl          = 1'b0;
                lvl          = last_sda_reg;
                bit_cnt_next = 4'd0;
                phase_next   = PH_TX_SET;
            end
            PH_TX_SET: begin
                scl        = 1'b0;
                lvl        = shift_reg[7];
                phase_next = PH_TX_HI;
            end
            PH_TX_HI: begin
                lvl        = shift_reg[7];
                phase_next = PH_TX_LO;
            end
            PH_TX_LO: begin
                scl          = 1'b0;
                lvl          = shift_reg[7];
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_inc;
                phase_next   = (bit_cnt_inc >= 4'd8) ? PH_ACK_L1 : PH_TX_SET;
            end
            PH_ACK_L1: begin
                scl        = 1'b0;
                drv        = 1'b0;
                phase_next = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                drv        = 1'b0;
                nack_next  = sda_in;
                phase_next = PH_ACK_L2;
            end
            PH_ACK_L2: begin
                scl = 1'b0;
                drv = 1'b0;
                if (nack_reg) begin
                    status_next = fail_code(lop_reg, byte_idx_reg);
                    phase_next  = PH_STO_A;
                end else if (lop_reg == OP_WRITE) begin
                    if (byte_idx_reg >= 2'd2) begin
                        status_next = ST_OK;
                        phase_next  = PH_STO_A;
                    end else begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                        shift_next    = pick_byte(lop_reg, byte_idx_reg + 2'd1, laddr_reg,
                                                  ldata_reg, dev_addr);
                        phase_next    = PH_TX_PREP;
                    end
                end else if (lop_reg == OP_CUR_READ || byte_idx_reg >= 2'd2) begin
                    phase_next = PH_RX_PREP;
                end else if (byte_idx_reg == 2'd0) begin
                    byte_idx_next = 2'd1;
                    shift_next    = pick_byte(lop_reg, 2'd1, laddr_reg, ldata_reg, dev_addr);
                    phase_next    = PH_TX_PREP;
                end else begin
                    // Random read: repeated start before the read address.
                    byte_idx_next = 2'd2;
                    phase_next    = PH_STA_A;
                end
            end
            PH_RX_PREP: begin
                scl          = 1'b0;
                drv          = 1'b0;
                bit_cnt_next = 4'd0;
                shift_next   = 8'd0;
                phase_next   = PH_RX_HI;
            end
            PH_RX_HI: begin
                drv        = 1'b0;
                shift_next = {shift_reg[6:0], sda_in};
                phase_next = PH_RX_LO;
            end
            PH_RX_LO: begin
                scl          = 1'b0;
                drv          = 1'b0;
                bit_cnt_next = bit_cnt_inc;
                if (bit_cnt_inc >= 4'd8) begin
                    rx_byte_next = shift_reg;
                    status_next  = ST_OK;
                    phase_next   = PH_NA_A;
                end else begin
                    phase_next = PH_RX_HI;
                end
            end
            PH_NA_A: begin
                scl        = 1'b0;
                lvl        = last_sda_reg;
                phase_next = PH_NA_B;
            end
            PH_NA_B: begin
                scl        = 1'b0;
                phase_next = PH_NA_C;
            end
            PH_NA_C: begin
                phase_next = PH_NA_D;
            end
            PH_NA_D: begin
                scl        = 1'b0;
                phase_next = PH_STO_A;
            end
            PH_STO_A: begin
                scl        = 1'b0;
                lvl        = 1'b0;
                phase_next = PH_STO_B;
            end
            PH_STO_B: begin
                lvl        = 1'b0;
                phase_next = PH_STO_C;
            end
            PH_STO_C: begin
                if (lop_reg == OP_WRITE && status_reg == ST_OK && wait_ticks != 16'd0) begin
                    wait_cnt_next = wait_ticks;
                    phase_next    = PH_WAIT;
                end else begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_WAIT: begin
                if (wait_cnt_reg <= 16'd1) begin
                    wait_cnt_next = 16'd0;
                    done          = 1'b1;
                    phase_next    = PH_IDLE;
                end else begin
                    wait_cnt_next = wait_cnt_reg - 16'd1;
                end
            end
            default: begin
                busy       = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase

        last_sda_next = last_sda_reg;
        if (drv) begin
            last_sda_next = lvl;
        end else begin
            lvl = 1'b1;
        end

        res.scl_level = scl;
        res.sda_level = lvl;
        res.sda_drive = drv;
        res.busy_res  = busy;
        res.done_res  = done;
        res.status    = status_next;
        res.read_data = rx_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            lop_reg      <= OP_TICK;
            laddr_reg    <= 8'd0;
            ldata_reg    <= 8'd0;
            wait_cnt_reg <= 16'd0;
            status_reg   <= ST_OK;
            rx_byte_reg  <= 8'd0;
            byte_idx_reg <= 2'd0;
            nack_reg     <= 1'b0;
            last_sda_reg <= 1'b1;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            lop_reg      <= lop_next;
            laddr_reg    <= laddr_next;
            ldata_reg    <= ldata_next;
            wait_cnt_reg <= wait_cnt_next;
            status_reg   <= status_next;
            rx_byte_reg  <= rx_byte_next;
            byte_idx_reg <= byte_idx_next;
            nack_reg     <= nack_next;
            last_sda_reg <= last_sda_next;
        end
    end

endmodule

`default_nettype wire

FILE: dv/i2c_eeprom_byte_master_top_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the EEPROM byte master. Every request is one bus
// tick. The bench plays the EEPROM side of the bus: it answers each ACK slot and
// each read bit from the transfer plan that is active, and it checks every tick
// result, field by field, against its own cycle-level model of the sequencer.
module i2c_eeprom_byte_master_top_test;
    import i2ceb_pkg::*;

    // The watchdog gives up when its quiet-cycle counter reaches this limit.
    localparam int QUIET_LIMIT = 4000;
    // Random ticks per random phase; every phase runs at least one transfer.
    localparam int PHASE_TICKS = 40;

    // One bus tick request as it travels on s_tdata.
    typedef struct packed {
        logic       sda;
        logic [7:0] data;
        logic [7:0] addr;
        op_t        op;
    } tick_t;

    // One row of the transfer plan. An OP_TICK row sends idle ticks only. The
    // ACK slot named by nack_at is answered with a NACK; slot 3 never comes, so
    // a nack_at of 3 means the EEPROM acknowledges everything.
    typedef struct {
        op_t        op;
        int         span;
        logic [7:0] addr;
        logic [7:0] data;
        int         nack_at;
        logic [7:0] rx;
        bit         set_cfg;
        logic [6:0] dev;
        logic [15:0] wait_n;
        bit         fix;
        status_t    fix_st;
        logic [7:0] fix_rd;
    } xfer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [23:0] s_tdata = '0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    wire logic   cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    i2c_eeprom_byte_master_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer model. It mirrors the register contents and the bus phase of
    // the block and is advanced once per accepted tick request.
    // ------------------------------------------------------------------------
    logic [6:0]  dev_addr   = DEV_ADDR_RST;
    logic [15:0] wait_ticks = WAIT_TICKS_RST;

    phase_t      bus_phase = PH_IDLE;
    logic [3:0]  bit_cnt   = '0;
    logic [7:0]  shreg     = '0;
    op_t         cmd_op    = OP_TICK;
    logic [7:0]  cmd_addr  = '0;
    logic [7:0]  cmd_data  = '0;
    logic [15:0] wait_left = '0;
    status_t     stat      = ST_OK;
    logic [7:0]  rx_last   = '0;
    logic [1:0]  byte_no   = '0;
    logic        nacked    = 1'b0;
    logic        sda_last  = 1'b1;

    // Expected tick results, oldest first.
    res_t        want_q[$];

    int          ticks_sent = 0;
    int          results_seen = 0;
    int          err_cnt = 0;
    int          nack_cnt = 0;
    int          op_cnt[4] = '{0, 0, 0, 0};

    // Next byte on the wire, chosen from the command and how many bytes are out.
    function automatic logic [7:0] next_out_byte();
        logic [7:0] wr_b;
        logic [7:0] rd_b;
        wr_b = {dev_addr, 1'b0};
        rd_b = {dev_addr, 1'b1};
        if (cmd_op == OP_WRITE) begin
            return (byte_no == 0) ? wr_b : (byte_no == 1) ? cmd_addr : cmd_data;
        end
        if (cmd_op == OP_CUR_READ) begin
            return rd_b;
        end
        return (byte_no == 0) ? wr_b : (byte_no == 1) ? cmd_addr : rd_b;
    endfunction

    // Outcome code when the EEPROM leaves the current ACK slot high.
    function automatic status_t nack_status();
        if (cmd_op == OP_CUR_READ) begin
            return ST_NACK_RADDR;
        end
        if (byte_no == 0) begin
            return ST_NACK_WADDR;
        end
        if (byte_no == 1) begin
            return ST_NACK_MADDR;
        end
        return (cmd_op == OP_WRITE) ? ST_NACK_DATA : ST_NACK_RADDR;
    endfunction

    // Advances the model by one tick and returns the result it should produce.
    function automatic res_t bus_tick(tick_t t);
        logic scl;
        logic lvl;
        logic drv;
        logic busy;
        logic done;
        res_t r;
        scl  = 1'b1;
        lvl  = 1'b1;
        drv  = 1'b1;
        busy = 1'b1;
        done = 1'b0;

        // A command only starts from idle; the start's first tick is this one.
        if (bus_phase == PH_IDLE && t.op != OP_TICK) begin
            cmd_op   = t.op;
            cmd_addr = t.addr;
            cmd_data = t.data;
            byte_no  = '0;
            bus_phase = PH_STA_A;
            op_cnt[t.op]++;
        end

        case (bus_phase)
            PH_IDLE: begin
                busy = 1'b0;
            end
            PH_STA_A: begin
                bus_phase = PH_STA_B;
            end
            PH_STA_B: begin
                lvl = 1'b0;
                shreg = next_out_byte();
                bus_phase = PH_TX_PREP;
            end
            PH_TX_PREP: begin
                scl = 1'b0;
                lvl = sda_last;
                bit_cnt = '0;
                bus_phase = PH_TX_SET;
            end
            PH_TX_SET: begin
                scl = 1'b0;
                lvl = shreg[7];
                bus_phase = PH_TX_HI;
            end
            PH_TX_HI: begin
                lvl = shreg[7];
                bus_phase = PH_TX_LO;
            end
            PH_TX_LO: begin
                scl = 1'b0;
                lvl = shreg[7];
                shreg = shreg << 1;
                bit_cnt = bit_cnt + 4'd1;
                bus_phase = (bit_cnt >= 4'd8) ? PH_ACK_L1 : PH_TX_SET;
            end
            PH_ACK_L1: begin
                scl = 1'b0;
                drv = 1'b0;
                bus_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                drv = 1'b0;
                nacked = t.sda;
                bus_phase = PH_ACK_L2;
            end
            PH_ACK_L2: begin
                scl = 1'b0;
                drv = 1'b0;
                if (nacked) begin
                    stat = nack_status();
                    bus_phase = PH_STO_A;
                end else if (cmd_op == OP_WRITE) begin
                    if (byte_no >= 2) begin
                        stat = ST_OK;
                        bus_phase = PH_STO_A;
                    end else begin
                        byte_no = byte_no + 2'd1;
                        shreg = next_out_byte();
                        bus_phase = PH_TX_PREP;
                    end
                end else if (cmd_op == OP_CUR_READ || byte_no >= 2) begin
                    bus_phase = PH_RX_PREP;
                end else if (byte_no == 0) begin
                    byte_no = 2'd1;
                    shreg = next_out_byte();
                    bus_phase = PH_TX_PREP;
                end else begin
                    // Word address is out: repeated start, then the read address.
                    byte_no = 2'd2;
                    bus_phase = PH_STA_A;
                end
            end
            PH_RX_PREP: begin
                scl = 1'b0;
                drv = 1'b0;
                bit_cnt = '0;
                shreg = '0;
                bus_phase = PH_RX_HI;
            end
            PH_RX_HI: begin
                drv = 1'b0;
                shreg = {shreg[6:0], t.sda};
                bus_phase = PH_RX_LO;
            end
            PH_RX_LO: begin
                scl = 1'b0;
                drv = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    rx_last = shreg;
                    stat = ST_OK;
                    bus_phase = PH_NA_A;
                end else begin
                    bus_phase = PH_RX_HI;
                end
            end
            PH_NA_A: begin
                scl = 1'b0;
                lvl = sda_last;
                bus_phase = PH_NA_B;
            end
            PH_NA_B: begin
                scl = 1'b0;
                bus_phase = PH_NA_C;
            end
            PH_NA_C: begin
                bus_phase = PH_NA_D;
            end
            PH_NA_D: begin
                scl = 1'b0;
                bus_phase = PH_STO_A;
            end
            PH_STO_A: begin
                scl = 1'b0;
                lvl = 1'b0;
                bus_phase = PH_STO_B;
            end
            PH_STO_B: begin
                lvl = 1'b0;
                bus_phase = PH_STO_C;
            end
            PH_STO_C: begin
                // Only a successful write goes on to the write wait.
                if (cmd_op == OP_WRITE && stat == ST_OK && wait_ticks != 0) begin
                    wait_left = wait_ticks;
                    bus_phase = PH_WAIT;
                end else begin
                    done = 1'b1;
                    bus_phase = PH_IDLE;
                end
            end
            PH_WAIT: begin
                if (wait_left <= 16'd1) begin
                    wait_left = '0;
                    done = 1'b1;
                    bus_phase = PH_IDLE;
                end else begin
                    wait_left = wait_left - 16'd1;
                end
            end
            default: begin
                busy = 1'b0;
                bus_phase = PH_IDLE;
            end
        endcase

        // A released line reads high; the last driven level is remembered.
        if (drv) begin
            sda_last = lvl;
        end else begin
            lvl = 1'b1;
        end
        if (done && stat != ST_OK) begin
            nack_cnt++;
        end

        r.scl_level = scl;
        r.sda_level = lvl;
        r.sda_drive = drv;
        r.busy_res  = busy;
        r.done_res  = done;
        r.status    = stat;
        r.read_data = rx_last;
        ticks_sent++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // EEPROM side of the bus. The transfer plan decides which ACK slot is
    // refused and which byte is returned; all other tick content is noise.
    // ------------------------------------------------------------------------
    xfer_t       plan;
    bit          cmd_pending = 1'b0;
    int          ack_slot = 0;
    int          rx_bit = 0;
    tick_t       pending;
    int unsigned send_gap_pct = 0;
    int unsigned sink_stall_pct = 0;

    // Builds the next request from the plan and the phase the block will be in.
    function automatic tick_t next_tick();
        tick_t t;
        t.op   = OP_TICK;
        t.addr = 8'($urandom);
        t.data = 8'($urandom);
        t.sda  = 1'($urandom);
        if (cmd_pending) begin
            t.op = plan.op;
            t.addr = plan.addr;
            t.data = plan.data;
            cmd_pending = 1'b0;
            ack_slot = 0;
            rx_bit = 0;
        end else if (bus_phase != PH_IDLE) begin
            // Commands while busy, the done tick included, must be ignored.
            t.op = op_t'($urandom_range(3));
            if (bus_phase == PH_ACK_HI) begin
                t.sda = (ack_slot == plan.nack_at);
                ack_slot++;
            end else if (bus_phase == PH_RX_HI) begin
                t.sda = plan.rx[7 - rx_bit];
                rx_bit++;
            end
        end
        return t;
    endfunction

    // Sends at least count requests; with to_idle set, keeps going until the
    // block is back in idle. Requests are built only when the previous one has
    // gone, so the model is always up to date when the bus answer is chosen.
    task automatic run_ticks(input int count, input bit to_idle);
        int   sent;
        bit   more;
        res_t r;
        sent = 0;
        more = 1'b1;
        while (more) begin
            @(posedge aclk);
            if (s_tvalid && s_tready) begin
                r = bus_tick(pending);
                // Directed rows carry the outcome typed in: on every idle tick,
                // and on the tick that ends a transfer.
                if (plan.fix && (plan.op == OP_TICK || r.done_res)) begin
                    r.status = plan.fix_st;
                    r.read_data = plan.fix_rd;
                end
                want_q.push_back(r);
                sent++;
            end
            more = (sent < count) || (to_idle && bus_phase != PH_IDLE);
            if (s_tvalid && !s_tready) begin
                // The request is held until the block takes it.
            end else if (more && $urandom_range(99) >= send_gap_pct) begin
                pending = next_tick();
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, pending};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    endtask

    task automatic drain();
        while (want_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DEV_ADDR) begin
            dev_addr = val[6:0];
        end else begin
            wait_ticks = val;
        end
    endtask

    // Carries out one plan row; registers only change once every result is in.
    task automatic run_plan(input xfer_t x);
        if (x.set_cfg) begin
            drain();
            write_reg(CFG_DEV_ADDR, {9'd0, x.dev});
            write_reg(CFG_WAIT_TICKS, x.wait_n);
        end else begin
            plan = x;
            if (x.op == OP_TICK) begin
                run_ticks(x.span, 1'b0);
            end else begin
                cmd_pending = 1'b1;
                run_ticks(1, 1'b1);
            end
        end
    endtask

    function automatic xfer_t row(op_t op, int nack_at, logic [7:0] addr, logic [7:0] data,
                                  logic [7:0] rx, status_t st, logic [7:0] rd);
        xfer_t x;
        x.op = op;
        x.span = 4;
        x.addr = addr;
        x.data = data;
        x.nack_at = nack_at;
        x.rx = rx;
        x.set_cfg = 1'b0;
        x.dev = '0;
        x.wait_n = '0;
        x.fix = 1'b1;
        x.fix_st = st;
        x.fix_rd = rd;
        return x;
    endfunction

    function automatic xfer_t cfg_row(logic [6:0] dev, logic [15:0] wait_n);
        xfer_t x;
        x = row(OP_TICK, 3, 8'h00, 8'h00, 8'h00, ST_OK, 8'h00);
        x.set_cfg = 1'b1;
        x.dev = dev;
        x.wait_n = wait_n;
        return x;
    endfunction

    // Random transfer: mostly clean; a quarter get a refused ACK slot from 0 to 2.
    function automatic xfer_t random_plan();
        xfer_t x;
        x = row(op_t'($urandom_range(1, 3)), 3, 8'($urandom), 8'($urandom),
                8'($urandom), ST_OK, 8'h00);
        if ($urandom_range(99) < 25) begin
            x.nack_at = $urandom_range(2);
        end
        x.fix = 1'b0;
        return x;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
        $display("result %0d: %s, expected %0d, got %0d", results_seen, what, exp_v,
                 got_v);
        err_cnt++;
    endtask

    res_t got_res;
    res_t want_res;

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            got_res = res_t'(m_tdata);
            if (want_q.size() == 0) begin
                flag_mismatch("result with no request behind it", 0, 1);
            end else begin
                want_res = want_q.pop_front();
                if (got_res.scl_level !== want_res.scl_level)
                    flag_mismatch("scl_level", want_res.scl_level, got_res.scl_level);
                if (got_res.sda_level !== want_res.sda_level)
                    flag_mismatch("sda_level", want_res.sda_level, got_res.sda_level);
                if (got_res.sda_drive !== want_res.sda_drive)
                    flag_mismatch("sda_drive", want_res.sda_drive, got_res.sda_drive);
                if (got_res.busy_res !== want_res.busy_res)
                    flag_mismatch("busy_res", want_res.busy_res, got_res.busy_res);
                if (got_res.done_res !== want_res.done_res)
                    flag_mismatch("done_res", want_res.done_res, got_res.done_res);
                if (got_res.status !== want_res.status)
                    flag_mismatch("status", want_res.status, got_res.status);
                if (got_res.read_data !== want_res.read_data)
                    flag_mismatch("read_data", want_res.read_data, got_res.read_data);
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // The run is abandoned once the quiet-cycle counter, which any handshake clears, reaches QUIET_LIMIT.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still pending",
                     quiet_cycles, want_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    xfer_t plan_tbl[$];
    int unsigned gap_mode[5]   = '{0, 0, 72, 0, 13};
    int unsigned stall_mode[5] = '{0, 0, 0, 72, 13};

    initial begin
        int start_ticks;

        // Directed rows. Statuses and read data are what the bus answers make
        // obvious. The device address keeps its reset value until the second
        // register row; the write wait is cut short right after the idle row.
        plan_tbl.push_back(row(OP_TICK,      3, 8'h00, 8'h00, 8'h00, ST_OK,         8'h00));
        plan_tbl.push_back(cfg_row(DEV_ADDR_RST, 16'd2));
        plan_tbl.push_back(row(OP_WRITE,     3, 8'h00, 8'hFF, 8'h00, ST_OK,         8'h00));
        plan_tbl.push_back(row(OP_CUR_READ,  3, 8'h00, 8'h00, 8'hA5, ST_OK,         8'hA5));
        plan_tbl.push_back(row(OP_RAND_READ, 3, 8'hFF, 8'h00, 8'h00, ST_OK,         8'h00));
        plan_tbl.push_back(row(OP_RAND_READ, 3, 8'h80, 8'hFF, 8'hFF, ST_OK,         8'hFF));
        // Refused ACKs: the status names the byte; read data is left alone.
        plan_tbl.push_back(row(OP_WRITE,     0, 8'h12, 8'h34, 8'h00, ST_NACK_WADDR, 8'hFF));
        plan_tbl.push_back(row(OP_WRITE,     1, 8'h56, 8'h78, 8'h00, ST_NACK_MADDR, 8'hFF));
        plan_tbl.push_back(row(OP_WRITE,     2, 8'h9A, 8'hBC, 8'h00, ST_NACK_DATA,  8'hFF));
        plan_tbl.push_back(row(OP_CUR_READ,  0, 8'h00, 8'h00, 8'h11, ST_NACK_RADDR, 8'hFF));
        plan_tbl.push_back(row(OP_RAND_READ, 0, 8'h01, 8'h00, 8'h22, ST_NACK_WADDR, 8'hFF));
        plan_tbl.push_back(row(OP_RAND_READ, 1, 8'h02, 8'h00, 8'h33, ST_NACK_MADDR, 8'hFF));
        plan_tbl.push_back(row(OP_RAND_READ, 2, 8'h03, 8'h00, 8'h44, ST_NACK_RADDR, 8'hFF));
        plan_tbl.push_back(row(OP_CUR_READ,  3, 8'h00, 8'h00, 8'h5A, ST_OK,         8'h5A));
        // Highest device address, and no write wait: done on the last stop tick.
        plan_tbl.push_back(cfg_row(7'd127, 16'd0));
        plan_tbl.push_back(row(OP_WRITE,     3, 8'hAA, 8'h55, 8'h00, ST_OK,         8'h5A));
        plan_tbl.push_back(row(OP_RAND_READ, 3, 8'h01, 8'h00, 8'hC3, ST_OK,         8'hC3));
        // Device address zero and the shortest non-zero wait.
        plan_tbl.push_back(cfg_row(7'd0, 16'd1));
        plan_tbl.push_back(row(OP_WRITE,     3, 8'hFF, 8'h00, 8'h00, ST_OK,         8'hC3));
        plan_tbl.push_back(row(OP_CUR_READ,  3, 8'h00, 8'h00, 8'h3C, ST_OK,         8'h3C));
        plan_tbl.push_back(row(OP_TICK,      3, 8'h00, 8'h00, 8'h00, ST_OK,         8'h3C));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan_tbl[i]) begin
            run_plan(plan_tbl[i]);
        end

        // Random phases, each with its own register values and idling pattern.
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            send_gap_pct = gap_mode[ph];
            sink_stall_pct = stall_mode[ph];
            write_reg(CFG_DEV_ADDR, 16'($urandom));
            write_reg(CFG_WAIT_TICKS, 16'($urandom_range(6)));
            start_ticks = ticks_sent;
            while (ticks_sent - start_ticks < PHASE_TICKS) begin
                plan = random_plan();
                if ($urandom_range(3) == 0) begin
                    run_ticks($urandom_range(1, 4), 1'b0);
                end
                cmd_pending = 1'b1;
                run_ticks(1, 1'b1);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (want_q.size() != 0) begin
            flag_mismatch("results never delivered", 0, want_q.size());
        end

        $display("ran %0d ticks: %0d byte writes, %0d current-address reads, %0d random reads",
                 ticks_sent, op_cnt[OP_WRITE], op_cnt[OP_CUR_READ], op_cnt[OP_RAND_READ]);
        $display("%0d transfers ended on a refused ACK; %0d results checked, %0d mismatches",
                 nack_cnt, results_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
